[sv/tcce_pkg.sv]
// Package for the text console cursor engine.
// Holds the screen geometry, field widths, opcodes, register indexes and shared structs.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package tcce_pkg;

  localparam int SCREEN_ROWS    = 25;
  localparam int SCREEN_COLUMNS = 80;
  localparam int CELL_COUNT     = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int COPY_COUNT     = CELL_COUNT - SCREEN_COLUMNS;
  localparam int ADDR_W         = $clog2(CELL_COUNT + 1);

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;

  localparam logic [7:0] LINE_FEED  = 8'd10;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam logic [3:0] FG_RESET = 4'd10;
  localparam logic [3:0] BG_RESET = 4'd5;

  localparam logic [3:0] CFG_FOREGROUND = 4'd0;
  localparam logic [3:0] CFG_BACKGROUND = 4'd1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SET   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Request from the controller to the sweep unit.
  typedef struct packed {
    logic start;
    logic scroll;
  } sweep_cmd_t;

  // Memory traffic and status from the sweep unit.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              copy;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              done;
  } sweep_mem_t;

endpackage

`default_nettype wire

[sv/tcce_screen_mem.sv]
// Screen store of the text console: one 16-bit cell per character position.
// One write port and one registered read port; imports tcce_pkg for its size.
`default_nettype none

module tcce_screen_mem
  import tcce_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [CELL_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] cells [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
    if (re) begin
      rdata <= cells[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/tcce_sweep.sv]
// Address sweep unit: walks the whole screen store one cell per cycle.
// Clears every cell, or scrolls up one row and blanks the bottom row; uses tcce_pkg.
`default_nettype none

module tcce_sweep
  import tcce_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire sweep_cmd_t cmd,
  output sweep_mem_t      mem
);

  logic              active;
  logic              scroll;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] wpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd.start) begin
      active <= 1'b1;
    end else if (active && cnt == ADDR_W'(CELL_COUNT)) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cnt    <= '0;
      scroll <= cmd.scroll;
    end else if (active) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Reads run ahead of writes, so the cell written at wpos is the
  // one read a row further down in the previous cycle.
  assign wpos      = cnt - 1'b1;
  assign mem.we    = active && cnt != '0;
  assign mem.waddr = wpos;
  assign mem.copy  = scroll && wpos < ADDR_W'(COPY_COUNT);
  assign mem.re    = active && scroll && cnt < ADDR_W'(COPY_COUNT);
  assign mem.raddr = cnt + ADDR_W'(SCREEN_COLUMNS);
  assign mem.done  = active && cnt == ADDR_W'(CELL_COUNT);

endmodule

`default_nettype wire

[sv/text_console_cursor_engine.sv]
// Text console cursor engine, top level: controller, cursor and colour registers.
// Instantiates tcce_screen_mem and tcce_sweep; imports tcce_pkg.
//
// Usage: an item on the input channel (in_valid/in_ready) carries an opcode and
// its operands: put character, clear screen, set cursor or read cell. Each item
// gives exactly one result on the output channel (out_valid/out_ready) with the
// cursor position after the item and, for a read, the addressed cell.
// The colour registers are written through cfg_valid/cfg_index/cfg_data, which
// is always ready; index 0 is the foreground, index 1 the background.
// A put, set cursor or read outside the store passes the execute and done states,
// a read inside it the read state between them. A clear, and any move that scrolls,
// walks the screen store once through the single write port of the store, one
// cell per cycle. The block takes one item at a time; in_ready is high only while
// no item is in work. A new item may be accepted while the previous result still
// waits on a stalled receiver; its result then waits until that one is taken.
// Reset homes the cursor, restores the colours and drops any pending result; the
// screen store holds no defined value until cleared.
`default_nettype none

module text_console_cursor_engine
  import tcce_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        opcode,
  input  wire logic [7:0]        char_code,
  input  wire logic [7:0]        target_column,
  input  wire logic [7:0]        target_row,
  input  wire logic [10:0]       cell_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [10:0]            cursor_index,
  output logic [ROW_W-1:0]       cursor_row_out,
  output logic [COL_W-1:0]       cursor_column_out,
  output logic [CELL_W-1:0]      read_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [3:0]        cfg_index,
  input  wire logic [3:0]        cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SWEEP = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [1:0]       op_q;
  logic [7:0]       char_q;
  logic [7:0]       tcol_q;
  logic [7:0]       trow_q;
  logic [10:0]      cidx_q;
  op_t              op;

  logic [3:0]       fg;
  logic [3:0]       bg;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [CELL_W-1:0] rdata_res;

  logic [7:0]       mv_col;
  logic [8:0]       mv_row;
  logic [8:0]       wr_row;
  logic [ROW_W-1:0] new_row;
  logic [COL_W-1:0] new_col;
  logic             mv_scroll;
  logic             is_lf;
  logic             read_ok;
  logic [ADDR_W-1:0] cur_pos;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;
  logic [CELL_W-1:0] blank_cell;

  sweep_cmd_t sw_cmd;
  sweep_mem_t sw_mem;

  assign op         = op_t'(op_q);
  assign is_lf      = char_q == LINE_FEED;
  assign read_ok    = cidx_q < 11'(CELL_COUNT);
  assign blank_cell = {bg, fg, SPACE_CHAR};
  assign cur_pos    = ADDR_W'(ADDR_W'(cur_row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(cur_col));

  assign in_ready  = state == S_IDLE;
  assign cfg_ready = 1'b1;

  // Requested cursor move of the current item, then column wrap and row pinning.
  always_comb begin
    mv_col = '0;
    mv_row = '0;
    unique case (op)
      OP_PUT: begin
        if (is_lf) begin
          mv_row = 9'(cur_row) + 9'd1;
        end else begin
          mv_col = 8'(cur_col) + 8'd1;
          mv_row = 9'(cur_row);
        end
      end
      OP_SET: begin
        mv_col = tcol_q;
        mv_row = 9'(trow_q);
      end
      OP_CLEAR: begin
        mv_col = '0;
        mv_row = '0;
      end
      OP_READ: begin
        mv_col = 8'(cur_col);
        mv_row = 9'(cur_row);
      end
      default: begin
        mv_col = '0;
        mv_row = '0;
      end
    endcase

    if (mv_col > 8'(SCREEN_COLUMNS - 1)) begin
      wr_row  = mv_row + 9'd1;
      new_col = '0;
    end else begin
      wr_row  = mv_row;
      new_col = mv_col[COL_W-1:0];
    end

    mv_scroll = wr_row > 9'(SCREEN_ROWS - 1);
    new_row   = mv_scroll ? ROW_W'(SCREEN_ROWS - 1) : wr_row[ROW_W-1:0];
  end

  always_comb begin
    sw_cmd.start  = state == S_EXEC && (op == OP_CLEAR || (op != OP_READ && mv_scroll));
    sw_cmd.scroll = op != OP_CLEAR;
  end

  // The put write and the read-cell read happen in the execute cycle; the
  // sweep owns both ports otherwise.
  always_comb begin
    if (state == S_EXEC && op == OP_PUT && !is_lf) begin
      mem_we    = 1'b1;
      mem_waddr = cur_pos;
      mem_wdata = {bg, fg, char_q};
    end else begin
      mem_we    = sw_mem.we;
      mem_waddr = sw_mem.waddr;
      mem_wdata = sw_mem.copy ? mem_rdata : blank_cell;
    end
    if (state == S_EXEC && op == OP_READ) begin
      mem_re    = read_ok;
      mem_raddr = cidx_q[ADDR_W-1:0];
    end else begin
      mem_re    = sw_mem.re;
      mem_raddr = sw_mem.raddr;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op == OP_READ) begin
          state_next = read_ok ? S_READ : S_DONE;
        end else if (sw_cmd.start) begin
          state_next = S_SWEEP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SWEEP: begin
        if (sw_mem.done) begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= opcode;
      char_q <= char_code;
      tcol_q <= target_column;
      trow_q <= target_row;
      cidx_q <= cell_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= FG_RESET;
      bg <= BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FOREGROUND) begin
        fg <= cfg_data;
      end else if (cfg_index == CFG_BACKGROUND) begin
        bg <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
    end else if (state == S_EXEC && op != OP_READ) begin
      cur_row <= new_row;
      cur_col <= new_col;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      rdata_res <= '0;
    end else if (state == S_READ) begin
      rdata_res <= mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      cursor_index      <= 11'(cur_pos);
      cursor_row_out    <= cur_row;
      cursor_column_out <= cur_col;
      read_data         <= rdata_res;
    end
  end

  tcce_screen_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcce_sweep u_sweep (
    .clk (clk),
    .rst (rst),
    .cmd (sw_cmd),
    .mem (sw_mem)
  );

endmodule

`default_nettype wire

[sim/tb_text_console_cursor_engine.sv]
// Self-checking testbench for text_console_cursor_engine.
// Mirrors the screen store, cursor and colours to predict every reply, using tcce_pkg.
// Directed corner cases first, then random phases with varied colours and idling.
`timescale 1ns / 1ps

module tb_text_console_cursor_engine;
  import tcce_pkg::*;

  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 228;
  localparam int HEAVY_PER_PHASE = 24;
  localparam int IDLE_PAUSE      = 16;
  localparam int WATCHDOG_LIMIT  = 20000;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic [7:0] tcol;
    logic [7:0] trow;
    logic [10:0] cidx;
  } console_item_t;

  typedef struct packed {
    logic [10:0]       idx;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] rdata;
  } console_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = '0;
  logic [7:0] char_code = '0;
  logic [7:0] target_column = '0;
  logic [7:0] target_row = '0;
  logic [10:0] cell_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [10:0] cursor_index;
  logic [ROW_W-1:0] cursor_row_out;
  logic [COL_W-1:0] cursor_column_out;
  logic [CELL_W-1:0] read_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  text_console_cursor_engine dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .opcode            (opcode),
    .char_code         (char_code),
    .target_column     (target_column),
    .target_row        (target_row),
    .cell_index        (cell_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .cursor_index      (cursor_index),
    .cursor_row_out    (cursor_row_out),
    .cursor_column_out (cursor_column_out),
    .read_data         (read_data),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block state, advanced on every accepted item.
  logic [CELL_W-1:0] screen_model [CELL_COUNT];
  int cur_row = 0;
  int cur_col = 0;
  logic [3:0] fg_model = FG_RESET;
  logic [3:0] bg_model = BG_RESET;

  console_item_t  queued_commands [$];
  console_reply_t expected_replies [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic in_fire = 1'b0;
  int mismatch_count = 0;
  int accepted_count = 0;
  int reply_count = 0;
  int scroll_count = 0;
  int clear_count = 0;
  int reg_write_count = 0;
  int stall_cycles = 0;

  // Generation-side cursor, so the random part can bound the number of slow items.
  int gen_row = 0;
  int gen_col = 0;
  int heavy_left = 0;

  function automatic bit wrap_position(input int col, input int row,
                                       output int ncol, output int nrow);
    ncol = col;
    nrow = row;
    if (ncol > SCREEN_COLUMNS - 1) begin
      nrow = nrow + 1;
      ncol = 0;
    end
    if (nrow > SCREEN_ROWS - 1) begin
      nrow = SCREEN_ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Moves a cursor as the item would; returns 1 when the item walks the whole store.
  function automatic bit track_cursor(input console_item_t it, inout int row, inout int col);
    case (it.op)
      OP_PUT: begin
        if (it.ch == LINE_FEED) return wrap_position(0, row + 1, col, row);
        return wrap_position(col + 1, row, col, row);
      end
      OP_CLEAR: begin
        row = 0;
        col = 0;
        return 1'b1;
      end
      OP_SET:  return wrap_position(it.tcol, it.trow, col, row);
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [CELL_W-1:0] colour_cell(input logic [7:0] ch);
    return {bg_model, fg_model, ch};
  endfunction

  function automatic console_reply_t console_step(input console_item_t it);
    console_reply_t res;
    res = '0;
    if (it.op == OP_PUT && it.ch != LINE_FEED)
      screen_model[cur_row * SCREEN_COLUMNS + cur_col] = colour_cell(it.ch);
    if (it.op == OP_CLEAR) begin
      for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = colour_cell(SPACE_CHAR);
      clear_count++;
    end
    if (it.op == OP_READ && it.cidx < CELL_COUNT) res.rdata = screen_model[it.cidx];
    if (track_cursor(it, cur_row, cur_col) && it.op != OP_CLEAR) begin
      for (int i = 0; i < COPY_COUNT; i++) screen_model[i] = screen_model[i + SCREEN_COLUMNS];
      for (int i = COPY_COUNT; i < CELL_COUNT; i++) screen_model[i] = colour_cell(SPACE_CHAR);
      scroll_count++;
    end
    res.idx = 11'(cur_row * SCREEN_COLUMNS + cur_col);
    res.row = ROW_W'(cur_row);
    res.col = COL_W'(cur_col);
    return res;
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] %s", $time, msg);
  endtask

  // Prediction on acceptance, checking of replies.
  always @(posedge clk) begin : check
    console_item_t  taken;
    console_reply_t want;
    console_reply_t seen;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        reg_write_count++;
        if (cfg_index == CFG_FOREGROUND) fg_model = cfg_data;
        else if (cfg_index == CFG_BACKGROUND) bg_model = cfg_data;
      end
      if (out_valid && out_ready) begin
        seen = '{cursor_index, cursor_row_out, cursor_column_out, read_data};
        reply_count++;
        if (expected_replies.size() == 0) begin
          flag_error($sformatf("unexpected reply idx %0d row %0d col %0d data %h",
                               seen.idx, seen.row, seen.col, seen.rdata));
        end else begin
          want = expected_replies.pop_front();
          if (seen.idx !== want.idx || seen.row !== want.row || seen.col !== want.col ||
              seen.rdata !== want.rdata)
            flag_error($sformatf({"reply %0d: expected idx %0d row %0d col %0d data %h, ",
                                  "got idx %0d row %0d col %0d data %h"}, reply_count,
                                 want.idx, want.row, want.col, want.rdata,
                                 seen.idx, seen.row, seen.col, seen.rdata));
        end
      end
      if (in_valid && in_ready) begin
        taken = '{op_t'(opcode), char_code, target_column, target_row, cell_index};
        accepted_count++;
        expected_replies.push_back(console_step(taken));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without progress", stall_cycles);
      $display("FAIL text_console_cursor_engine");
      $finish;
    end
  end

  // Item driver and reply back-pressure, both on the falling edge.
  always @(negedge clk) begin : drive
    console_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!in_valid || in_fire) begin
        if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = queued_commands.pop_front();
          in_valid <= 1'b1;
          opcode <= nxt.op;
          char_code <= nxt.ch;
          target_column <= nxt.tcol;
          target_row <= nxt.trow;
          cell_index <= nxt.cidx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic enqueue_item(input console_item_t it);
    void'(track_cursor(it, gen_row, gen_col));
    queued_commands.push_back(it);
  endtask

  task automatic write_colour_reg(input logic [3:0] idx, input logic [3:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (queued_commands.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  // Mostly text runs and in-range moves; some full-range values to hit every field bit.
  function automatic console_item_t random_item();
    console_item_t it;
    int roll;
    it.op = op_t'($urandom_range(3));
    it.ch = 8'($urandom);
    it.tcol = 8'($urandom);
    it.trow = 8'($urandom);
    it.cidx = 11'($urandom);
    roll = $urandom_range(99);
    if (roll < 55) begin
      it.op = OP_PUT;
      if ($urandom_range(99) < 6) it.ch = LINE_FEED;
      else if ($urandom_range(99) < 70) it.ch = 8'($urandom_range(8'h7E, 8'h20));
    end else if (roll < 75) begin
      it.op = OP_SET;
      if ($urandom_range(99) < 85) begin
        it.tcol = 8'($urandom_range(SCREEN_COLUMNS - 1));
        it.trow = 8'($urandom_range(SCREEN_ROWS - 1));
      end
    end else if (roll < 97) begin
      it.op = OP_READ;
      if ($urandom_range(99) < 90) it.cidx = 11'($urandom_range(CELL_COUNT - 1));
      else it.cidx = 11'($urandom_range(2047, CELL_COUNT));
    end else begin
      it.op = OP_CLEAR;
    end
    return it;
  endfunction

  initial begin : stimulus
    console_item_t it;
    int r;
    int c;
    logic [3:0] fg;
    logic [3:0] bg;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Clear first so that every later read hits a written cell.
    enqueue_item(console_item_t'{OP_CLEAR, 8'h00, 8'h00, 8'h00, 11'd0});
    enqueue_item(console_item_t'{OP_READ, 8'h00, 8'h00, 8'h00, 11'd0});
    enqueue_item(console_item_t'{OP_READ, 8'h00, 8'h00, 8'h00, 11'(CELL_COUNT - 1)});
    enqueue_item(console_item_t'{OP_READ, 8'h00, 8'h00, 8'h00, 11'(CELL_COUNT)});
    enqueue_item(console_item_t'{OP_READ, 8'h00, 8'h00, 8'h00, 11'h7FF});
    enqueue_item(console_item_t'{OP_PUT, 8'h41, 8'h00, 8'h00, 11'd0});
    enqueue_item(console_item_t'{OP_PUT, 8'h00, 8'h00, 8'h00, 11'd0});
    enqueue_item(console_item_t'{OP_PUT, 8'hFF, 8'h00, 8'h00, 11'd0});
    enqueue_item(console_item_t'{OP_PUT, LINE_FEED, 8'h00, 8'h00, 11'd0});
    enqueue_item(console_item_t'{OP_SET, 8'h00, 8'(SCREEN_COLUMNS - 1), 8'h00, 11'd0});
    enqueue_item(console_item_t'{OP_PUT, 8'h78, 8'h00, 8'h00, 11'd0});
    enqueue_item(console_item_t'{OP_SET, 8'h00, 8'(SCREEN_COLUMNS), 8'd3, 11'd0});
    enqueue_item(console_item_t'{OP_SET, 8'h00, 8'hFF, 8'hFF, 11'd0});
    enqueue_item(console_item_t'{OP_SET, 8'h00, 8'h00, 8'(SCREEN_ROWS - 1), 11'd0});
    enqueue_item(console_item_t'{OP_PUT, LINE_FEED, 8'h00, 8'h00, 11'd0});
    enqueue_item(console_item_t'{OP_SET, 8'h00, 8'(SCREEN_COLUMNS - 1),
                                 8'(SCREEN_ROWS - 1), 11'd0});
    enqueue_item(console_item_t'{OP_PUT, 8'h7A, 8'h00, 8'h00, 11'd0});
    enqueue_item(console_item_t'{OP_READ, 8'h00, 8'h00, 8'h00, 11'(COPY_COUNT - 1)});
    enqueue_item(console_item_t'{OP_READ, 8'h00, 8'h00, 8'h00, 11'(COPY_COUNT)});
    enqueue_item(console_item_t'{OP_SET, 8'h00, 8'h00, 8'(SCREEN_ROWS), 11'd0});
    enqueue_item(console_item_t'{OP_SET, 8'h00, 8'd12, 8'd7, 11'd0});
    enqueue_item(console_item_t'{OP_READ, 8'h00, 8'h00, 8'h00, 11'd2});
    enqueue_item(console_item_t'{OP_PUT, 8'h7E, 8'h00, 8'h00, 11'd0});
    enqueue_item(console_item_t'{OP_READ, 8'h00, 8'h00, 8'h00, 11'(7 * SCREEN_COLUMNS + 12)});

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      // Writes to unused indexes must leave both colours alone.
      if (!p[0]) write_colour_reg(4'(CFG_BACKGROUND + $urandom_range(1, 14)), 4'($urandom));
      fg = (p < 4) ? {4{p[0]}} : 4'($urandom);
      bg = (p < 4) ? {4{p[0] ^ p[1]}} : 4'($urandom);
      write_colour_reg(CFG_FOREGROUND, fg);
      write_colour_reg(CFG_BACKGROUND, bg);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      // Clears and scrolls take a full store pass each, so their number is bounded.
      heavy_left = HEAVY_PER_PHASE;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it = random_item();
        r = gen_row;
        c = gen_col;
        if (track_cursor(it, r, c)) begin
          if (heavy_left == 0) begin
            it.op = OP_SET;
            it.tcol = 8'($urandom_range(SCREEN_COLUMNS - 1));
            it.trow = 8'($urandom_range(SCREEN_ROWS - 1));
          end else begin
            heavy_left--;
          end
        end
        enqueue_item(it);
      end
    end
    wait_idle();

    $display("Covered %0d items and %0d replies in %0d random phases of colours and idling,",
             accepted_count, reply_count, RANDOM_PHASES);
    $display("with %0d clears, %0d scrolls, %0d register writes and %0d mismatches.",
             clear_count, scroll_count, reg_write_count, mismatch_count);
    if (mismatch_count == 0 && expected_replies.size() == 0)
      $display("PASS text_console_cursor_engine");
    else
      $display("FAIL text_console_cursor_engine");
    $finish;
  end

endmodule

[files.f]
sv/tcce_pkg.sv
sv/tcce_screen_mem.sv
sv/tcce_sweep.sv
sv/text_console_cursor_engine.sv
sim/tb_text_console_cursor_engine.sv
